@@ rtl/utf8_sequence_filter_assert.svh @@
// Assertion macros shared by the filter's modules.
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef UTF8_SEQUENCE_FILTER_ASSERT_SVH
`define UTF8_SEQUENCE_FILTER_ASSERT_SVH

// The expression must hold at every clock edge outside reset.
`define U8SF_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// When the condition holds, the expression must hold in the next cycle.
`define U8SF_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

@@ rtl/u8sf_pkg.sv @@
package u8sf_pkg;

    // Byte classification masks and codes.
    localparam logic [7:0] ContMask  = 8'hC0;
    localparam logic [7:0] ContCode  = 8'h80;
    localparam logic [7:0] Lead2Mask = 8'hE0;
    localparam logic [7:0] Lead2Code = 8'hC0;
    localparam logic [7:0] Lead3Mask = 8'hF0;
    localparam logic [7:0] Lead3Code = 8'hE0;
    localparam logic [7:0] Lead4Mask = 8'hF8;
    localparam logic [7:0] Lead4Code = 8'hF0;

    // Default depth of the queue between front and back.
    localparam int DefaultQueueDepth = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       string_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_present;
        logic       string_done;
        logic       run_last;
    } t_out_item;

    // One burst of results caused by a single input byte.
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            present;
        logic            done;
    } t_job;

endpackage

@@ rtl/u8sf_front.sv @@
`include "utf8_sequence_filter_assert.svh"

module u8sf_front
    import u8sf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    input  logic     i_full,
    output logic     o_in_stall,
    output logic     o_push,
    output t_job     o_job
);

    logic [2:0][7:0] r_held;
    logic [1:0]      r_hc;
    logic [1:0]      r_need;
    logic [1:0]      n_hc;
    logic [1:0]      n_need;
    logic            held_we;
    logic [1:0]      held_idx;
    logic            emit;
    logic            accept;
    logic [7:0]      b;
    t_job            job;

    assign b          = i_in_data.in_byte;
    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    always_comb begin
        n_hc          = r_hc;
        n_need        = r_need;
        held_we       = 1'b0;
        held_idx      = 2'd0;
        emit          = 1'b0;
        job.bytes[0]  = r_held[0];
        job.bytes[1]  = r_held[1];
        job.bytes[2]  = r_held[2];
        job.bytes[3]  = b;
        job.last_idx  = 2'd0;
        job.present   = 1'b1;
        job.done      = 1'b0;

        if ((b & ContMask) == ContCode) begin
            if (r_need == 2'd1) begin
                // The final continuation completes the held sequence.
                emit             = 1'b1;
                job.bytes[r_hc]  = b;
                job.last_idx     = r_hc;
                n_hc             = 2'd0;
                n_need           = 2'd0;
            end else if (r_need > 2'd1 && r_hc < 2'd3) begin
                held_we  = 1'b1;
                held_idx = r_hc;
                n_hc     = r_hc + 2'd1;
                n_need   = r_need - 2'd1;
            end else begin
                n_hc   = 2'd0;
                n_need = 2'd0;
            end
        end else begin
            // Any open sequence is abandoned before the new byte is handled.
            n_hc   = 2'd0;
            n_need = 2'd0;
            if (!b[7]) begin
                emit         = 1'b1;
                job.bytes[0] = b;
            end else if ((b & Lead2Mask) == Lead2Code) begin
                held_we = 1'b1;
                n_hc    = 2'd1;
                n_need  = 2'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
                held_we = 1'b1;
                n_hc    = 2'd1;
                n_need  = 2'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
                held_we = 1'b1;
                n_hc    = 2'd1;
                n_need  = 2'd3;
            end
        end

        if (i_in_data.string_end) begin
            n_hc   = 2'd0;
            n_need = 2'd0;
            if (!emit) begin
                // Nothing to emit, so a bare end marker goes out.
                emit         = 1'b1;
                job.bytes[0] = 8'h00;
                job.present  = 1'b0;
                job.last_idx = 2'd0;
            end
            job.done = 1'b1;
        end
    end

    assign o_push = accept && emit;
    assign o_job  = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc   <= 2'd0;
            r_need <= 2'd0;
        end else if (accept) begin
            r_hc   <= n_hc;
            r_need <= n_need;
        end
        if (accept && held_we) begin
            r_held[held_idx] <= b;
        end
    end

    `U8SF_ASSERT_NEXT(a_end_clears, accept && i_in_data.string_end,
        r_hc == 2'd0 && r_need == 2'd0, "open sequence survived string end")
    `U8SF_ASSERT_ALWAYS(a_need_implies_held, r_need == 2'd0 || r_hc != 2'd0,
        "continuations pending with no lead held")
    `U8SF_ASSERT_ALWAYS(a_seq_length, ({1'b0, r_hc} + {1'b0, r_need}) <= 3'd4,
        "open sequence longer than four bytes")

endmodule

@@ rtl/u8sf_queue.sv @@
`include "utf8_sequence_filter_assert.svh"

module u8sf_queue
    import u8sf_pkg::*;
#(
    parameter int Depth = DefaultQueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    t_job            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr;
    logic [CntW-1:0] r_count;

    assign o_full       = (r_count == CntW'(Depth));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `U8SF_ASSERT_ALWAYS(a_no_overflow, !(i_push && o_full), "push into a full queue")
    `U8SF_ASSERT_ALWAYS(a_no_underflow, !(i_pop && !o_head_valid),
        "pop from an empty queue")
    `U8SF_ASSERT_ALWAYS(a_count_range, r_count <= CntW'(Depth),
        "queue count beyond its depth")

endmodule

@@ rtl/u8sf_back.sv @@
module u8sf_back
    import u8sf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data
);

    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       load;
    logic       is_last;

    // With a job waiting, the output register refills when it is empty or being taken.
    assign load    = i_head_valid && (!r_out_valid || !i_out_stall);
    assign is_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_out.out_byte     <= i_head.bytes[r_idx];
            r_out.byte_present <= i_head.present;
            r_out.string_done  <= is_last && i_head.done;
            r_out.run_last     <= is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/utf8_sequence_filter.sv @@
// UTF-8 sequence filter: takes one string byte per transfer on the input
// channel and passes on only structurally complete UTF-8 sequences on the
// output channel, one byte per transfer. Both channels use valid and stall.
// An input byte that completes a sequence causes a burst of up to four
// output transfers; a byte with string_end set always causes at least one,
// a bare end marker if it completes nothing. run_last flags the final
// transfer caused by an input byte, string_done the final one of a string.
// The front part accepts one byte every cycle while the queue is not full,
// classifies it and tracks the open sequence; each burst then waits in a
// short job queue for the back part, which sends one result per cycle
// through a registered output while the output is not stalled. The
// input sustains one byte per cycle as long as the output keeps up; the
// output side delivers at most one result per cycle, so long bursts are
// absorbed by the queue and then stall the input once it fills.
// A stalled output simply holds its result; the queue fills and the input
// stall rises. Reset empties the queue and the output register and drops
// any open sequence; no clearing pass is needed.
module utf8_sequence_filter
    import u8sf_pkg::*;
#(
    parameter int QueueDepth = DefaultQueueDepth  // job queue entries, 2 or more
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic full;
    logic push;
    logic pop;
    logic head_valid;
    t_job job;
    t_job head;

    // Classification and open-sequence tracking.
    u8sf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_job      (job)
    );

    // Bursts waiting for the output side.
    u8sf_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // Serializes each burst into output transfers.
    u8sf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .i_out_stall  (i_out_stall),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top
    import u8sf_pkg::*;
();

    // Clock and reset. The clock has a 2 ns period.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Channel signals. Every input of the block starts at a known value.
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    utf8_sequence_filter u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // When idling is set, the sender leaves random gaps between transfers
    // and the receiver stalls at random. When it is clear, both sides run at
    // full rate, so the only stalls are those the block raises itself.
    logic idling = 1'b0;

    int mismatches = 0;
    int items_sent = 0;
    int stall_cnt = 0;

    // Results the block still owes us, oldest first.
    t_out_item filtered_q [$];

    // Our own copy of the open sequence: the bytes held so far, how many
    // there are, and how many continuation bytes are still missing.
    logic [7:0] held [3];
    logic [1:0] held_n = '0;
    logic [1:0] need_n = '0;

    // Bytes of the string that is being assembled for sending.
    logic [7:0] text_buf [$];

    // Checker scratch.
    t_out_item seen;
    t_out_item due;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatches++;
    endtask

    // Gap lengths: mostly short, now and then a long one.
    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 20);
    endfunction

    function automatic t_out_item byte_result(input logic [7:0] b);
        t_out_item r;
        r = '0;
        r.out_byte = b;
        r.byte_present = 1'b1;
        return r;
    endfunction

    // Works out the burst of results that one accepted input byte causes,
    // updates the open sequence, and queues the burst in order.
    task automatic filter_byte(input logic [7:0] b, input logic last);
        t_out_item burst [$];
        t_out_item r;
        if ((b & ContMask) == ContCode) begin
            if (need_n == 2'd1) begin
                // This continuation completes the sequence: release it whole.
                for (int i = 0; i < held_n; i++) begin
                    burst.push_back(byte_result(held[i]));
                end
                burst.push_back(byte_result(b));
                {held_n, need_n} = '0;
            end else if (need_n > 2'd1 && held_n < 2'd3) begin
                held[held_n] = b;
                held_n = held_n + 2'd1;
                need_n = need_n - 2'd1;
            end else begin
                // A continuation with nothing open is simply dropped.
                {held_n, need_n} = '0;
            end
        end else begin
            // Any other byte discards an unfinished sequence first.
            {held_n, need_n} = '0;
            if (!b[7]) begin
                burst.push_back(byte_result(b));
            end else if ((b & Lead2Mask) == Lead2Code) begin
                held[0] = b;
                held_n = 2'd1;
                need_n = 2'd1;
            end else if ((b & Lead3Mask) == Lead3Code) begin
                held[0] = b;
                held_n = 2'd1;
                need_n = 2'd2;
            end else if ((b & Lead4Mask) == Lead4Code) begin
                held[0] = b;
                held_n = 2'd1;
                need_n = 2'd3;
            end
            // Bytes F8 to FF fall through and are dropped.
        end

        if (last) begin
            // The string ends here, so whatever is still open is lost. A
            // string end that releases nothing still produces a bare marker.
            {held_n, need_n} = '0;
            if (burst.size() == 0) begin
                burst.push_back('0);
            end
        end
        if (burst.size() != 0) begin
            r = burst.pop_back();
            r.run_last = 1'b1;
            r.string_done = last;
            burst.push_back(r);
        end
        foreach (burst[i]) begin
            filtered_q.push_back(burst[i]);
        end
    endtask

    // Sends one byte. Valid stays high from one transfer to the next unless a
    // gap is taken, and the payload holds still until the transfer happens.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        if (idling && $urandom_range(0, 2) == 0) begin
            gap = pick_gap();
        end
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data.in_byte <= b;
        in_data.string_end <= last;
        do @(posedge clk); while (in_stall);
        filter_byte(b, last);
        items_sent++;
    endtask

    // Sends the assembled string, flagging its final byte as the end.
    task automatic send_text();
        foreach (text_buf[i]) begin
            send_byte(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    // Appends a lead byte for a sequence of len bytes (2 to 4) followed by
    // conts continuation bytes, all with random payload bits.
    task automatic add_seq(input int len, input int conts);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            2: text_buf.push_back({3'b110, r[4:0]});
            3: text_buf.push_back({4'b1110, r[3:0]});
            default: text_buf.push_back({5'b11110, r[2:0]});
        endcase
        repeat (conts) begin
            r = 8'($urandom);
            text_buf.push_back({2'b10, r[5:0]});
        end
    endtask

    // Appends one random piece of text. Most pieces are well-formed
    // characters; the rest are cut-off sequences, stray continuations,
    // invalid leads, surplus continuations and plain random bytes.
    task automatic add_token();
        int sel;
        int len;
        logic [7:0] r;
        sel = $urandom_range(0, 99);
        len = $urandom_range(2, 4);
        r = 8'($urandom);
        if (sel < 30) begin
            text_buf.push_back({1'b0, r[6:0]});
        end else if (sel < 72) begin
            add_seq(len, len - 1);
        end else if (sel < 79) begin
            add_seq(len, $urandom_range(0, len - 2));
        end else if (sel < 85) begin
            text_buf.push_back({2'b10, r[5:0]});
        end else if (sel < 89) begin
            text_buf.push_back({5'b11111, r[2:0]});
        end else if (sel < 94) begin
            add_seq(len, len);
        end else begin
            text_buf.push_back(r);
        end
    endtask

    // Random strings of one to eight pieces until the item count is reached.
    task automatic send_random_text(input int count);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at) begin
            repeat ($urandom_range(1, 8)) add_token();
            send_text();
        end
    endtask

    // ASCII at both ends of its range, and complete sequences of two, three
    // and four bytes, the last with the highest lead and continuation values.
    task automatic test_valid_sequences();
        text_buf = '{8'h00, 8'h7F};
        send_text();
        text_buf = '{8'hC2, 8'hA9};
        send_text();
        text_buf = '{8'hE2, 8'h82, 8'hAC};
        send_text();
        text_buf = '{8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_text();
    endtask

    // Stray continuations, invalid leads, sequences cut short by ASCII, by a
    // new lead and by an invalid byte, a string end that releases nothing,
    // and a sequence left unfinished when the string ends.
    task automatic test_malformed_bytes();
        text_buf = '{8'h80, 8'hFF, 8'hF8, 8'h41};
        send_text();
        text_buf = '{8'hE2, 8'h82, 8'h41};
        send_text();
        text_buf = '{8'hC3, 8'hF0, 8'h9F, 8'hFE};
        send_text();
        text_buf = '{8'hF0, 8'h9F, 8'h8F};
        send_text();
    endtask

    task automatic test_random_text();
        send_random_text(260);
    endtask

    // No gaps and no output stalls: input bytes arrive every cycle, so long
    // bursts have to back up into the input stall.
    task automatic test_full_rate();
        idling = 1'b0;
        send_random_text(40);
    endtask

    // Receiver stall pattern. A stall of random length starts now and then
    // while idling is on; otherwise the receiver takes every result.
    always @(posedge clk) begin
        if (stall_cnt != 0) begin
            out_stall <= 1'b1;
            stall_cnt <= stall_cnt - 1;
        end else begin
            out_stall <= 1'b0;
            if (idling && $urandom_range(0, 3) == 0) begin
                stall_cnt <= pick_gap();
            end
        end
    end

    // Every result transfer is matched against the oldest outstanding
    // expectation, field by field.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            seen = out_data;
            if (filtered_q.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result byte=%02h present=%0b done=%0b last=%0b",
                    seen.out_byte, seen.byte_present, seen.string_done, seen.run_last));
            end else begin
                due = filtered_q.pop_front();
                if (seen.out_byte !== due.out_byte
                        || seen.byte_present !== due.byte_present
                        || seen.string_done !== due.string_done
                        || seen.run_last !== due.run_last) begin
                    report_mismatch($sformatf(
                        "got byte=%02h present=%0b done=%0b last=%0b, want %02h %0b %0b %0b",
                        seen.out_byte, seen.byte_present, seen.string_done, seen.run_last,
                        due.out_byte, due.byte_present, due.string_done, due.run_last));
                end
            end
        end
    end

    initial begin
        int guard;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        idling = 1'b1;

        test_valid_sequences();
        test_malformed_bytes();
        test_random_text();
        test_full_rate();

        in_valid <= 1'b0;

        // Let the block drain its queue, then keep clocking so that any surplus
        // result has a chance to show up.
        guard = 0;
        while (filtered_q.size() != 0 && guard < 5000) begin
            @(posedge clk);
            guard++;
        end
        if (filtered_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", filtered_q.size()));
        end
        repeat (10) @(posedge clk);

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog: far longer than the slowest correct run could take.
    initial begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/u8sf_pkg.sv
rtl/u8sf_front.sv
rtl/u8sf_queue.sv
rtl/u8sf_back.sv
rtl/utf8_sequence_filter.sv
tb/tb_top.sv
